// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the ranging sequencer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define UERS_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// clocked assertion that also holds during reset
`define UERS_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- design/uers_pkg.sv -----
// ----------------------------------------------------------------------------
// uers_pkg
// types, register indexes and reset values of the echo ranging sequencer
// ----------------------------------------------------------------------------
package uers_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;

  localparam cfg_idx_t REG_PERIOD    = 3'd0;
  localparam cfg_idx_t REG_BURST     = 3'd1;
  localparam cfg_idx_t REG_LISTEN    = 3'd2;
  localparam cfg_idx_t REG_MIN_WIDTH = 3'd3;
  localparam cfg_idx_t REG_MAX_WIDTH = 3'd4;

  localparam cfg_word_t PERIOD_RST    = 16'd2000;
  localparam cfg_word_t BURST_RST     = 16'd20;
  localparam cfg_word_t LISTEN_RST    = 16'd400;
  localparam cfg_word_t MIN_WIDTH_RST = 16'd4;
  localparam cfg_word_t MAX_WIDTH_RST = 16'd12;

  typedef struct packed {
    cfg_word_t period_ticks;
    cfg_word_t burst_ticks;
    cfg_word_t listen_end;
    cfg_word_t min_width;
    cfg_word_t max_width;
  } cfg_t;

  typedef struct packed {
    logic echo_level;
  } in_payload_t;

  typedef struct packed {
    logic      trigger_out;
    logic      indicator_on;
    cfg_word_t echo_width;
    logic      width_valid;
  } out_payload_t;

endpackage

// ----- design/uers_stream_if.sv -----
// ----------------------------------------------------------------------------
// uers_stream_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface uers_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/uers_cfg.sv -----
// ----------------------------------------------------------------------------
// uers_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module uers_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  uers_pkg::cfg_idx_t cfg_index,
  input  uers_pkg::cfg_word_t cfg_wdata,
  output uers_pkg::cfg_t     cfg
);

  uers_pkg::cfg_t cfg_r;
  uers_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        uers_pkg::REG_PERIOD:    cfg_nxt.period_ticks = cfg_wdata;
        uers_pkg::REG_BURST:     cfg_nxt.burst_ticks  = cfg_wdata;
        uers_pkg::REG_LISTEN:    cfg_nxt.listen_end   = cfg_wdata;
        uers_pkg::REG_MIN_WIDTH: cfg_nxt.min_width    = cfg_wdata;
        uers_pkg::REG_MAX_WIDTH: cfg_nxt.max_width    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ticks <= uers_pkg::PERIOD_RST;
      cfg_r.burst_ticks  <= uers_pkg::BURST_RST;
      cfg_r.listen_end   <= uers_pkg::LISTEN_RST;
      cfg_r.min_width    <= uers_pkg::MIN_WIDTH_RST;
      cfg_r.max_width    <= uers_pkg::MAX_WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/uers_core.sv -----
// ----------------------------------------------------------------------------
// uers_core
// tick counter, trigger, echo capture and indicator state for one tick
// ----------------------------------------------------------------------------
module uers_core #(
  parameter int COUNT_WIDTH = uers_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  uers_pkg::cfg_t         cfg,
  input  logic                   step_en,
  input  logic                   echo_level,
  output uers_pkg::out_payload_t result
);

  localparam int CMP_W = (COUNT_WIDTH > uers_pkg::CFG_W) ? COUNT_WIDTH : uers_pkg::CFG_W;

  logic [COUNT_WIDTH-1:0] tick_r,  tick_nxt;
  logic [COUNT_WIDTH-1:0] start_r, start_nxt;
  logic [COUNT_WIDTH-1:0] width_r, width_nxt;
  logic                   done_r,  done_nxt;
  logic                   trig_r,  trig_nxt;
  logic                   ind_r,   ind_nxt;

  logic [CMP_W-1:0]       t_x, burst_x, listen_x, period_x, min_x, max_x, width_x, wrap_x;
  logic [COUNT_WIDTH-1:0] inc;
  logic                   past_burst;

  always_comb begin
    t_x      = CMP_W'(tick_r);
    burst_x  = CMP_W'(cfg.burst_ticks);
    listen_x = CMP_W'(cfg.listen_end);
    period_x = CMP_W'(cfg.period_ticks);
    min_x    = CMP_W'(cfg.min_width);
    max_x    = CMP_W'(cfg.max_width);

    start_nxt = start_r;
    width_nxt = width_r;
    done_nxt  = done_r;
    trig_nxt  = trig_r;
    ind_nxt   = ind_r;

    past_burst = (t_x > burst_x);

    if (tick_r == '0) begin
      trig_nxt  = 1'b1;
      start_nxt = '0;
      width_nxt = '0;
      done_nxt  = 1'b0;
      ind_nxt   = 1'b1;
    end else if (t_x == burst_x) begin
      trig_nxt = 1'b0;
    end else if (past_burst && (t_x < listen_x)) begin
      // a zero start means no rising echo seen yet
      if (echo_level && (start_r == '0)) begin
        start_nxt = tick_r;
      end else if (!echo_level && (start_r != '0) && !done_r) begin
        width_nxt = tick_r - start_r;
        done_nxt  = 1'b1;
      end
    end

    width_x = CMP_W'(width_nxt);
    if (past_burst && (t_x < period_x) && done_nxt && (width_x > min_x) && (width_x < max_x)) begin
      ind_nxt = 1'b0;
    end

    // counter-wide increment, wraps at the counter width; the tick goes back to zero at the period
    inc    = tick_r + COUNT_WIDTH'(1);
    wrap_x = CMP_W'(inc);
    tick_nxt = (wrap_x >= period_x) ? '0 : inc;

    result.trigger_out  = trig_nxt;
    result.indicator_on = ind_nxt;
    result.echo_width   = width_x[uers_pkg::CFG_W-1:0];
    result.width_valid  = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      start_r <= '0;
      width_r <= '0;
      done_r  <= 1'b0;
      trig_r  <= 1'b0;
      ind_r   <= 1'b1;
    end else if (step_en) begin
      tick_r  <= tick_nxt;
      start_r <= start_nxt;
      width_r <= width_nxt;
      done_r  <= done_nxt;
      trig_r  <= trig_nxt;
      ind_r   <= ind_nxt;
    end
  end

endmodule

// ----- design/ultrasonic_echo_ranging_sequencer.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging_sequencer
// drives the sensor trigger and measures the echo pulse width, one tick a word
// ----------------------------------------------------------------------------
// usage:
//   in_word carries one timer tick per word with the sampled echo level.
//   out_word returns one word per tick: trigger level, indicator, echo width
//   and width valid, all as they stand after that tick.
//   cfg_we/cfg_index/cfg_wdata write the period, burst, listen end and the
//   width bounds; write only while no words are in flight.
// timing:
//   an input word goes into an input register, is worked against the tick
//   state combinationally, and lands in the output register, where it is
//   valid on out_word. One word per cycle is sustained while out_word is
//   not stalled; the combinational state update sets that rate.
// reset:
//   rst_n clears the tick counter, capture and trigger, lights the indicator
//   and loads the default register values; both channels come up empty.
// stalls:
//   while out_word is held, the output register keeps its word and one more
//   word waits in the input register; in_ready drops only once both are full.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging_sequencer #(
  parameter int COUNT_WIDTH = uers_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  uers_stream_if.sink         in_word,
  uers_stream_if.source       out_word,
  input  logic                cfg_we,
  input  uers_pkg::cfg_idx_t  cfg_index,
  input  uers_pkg::cfg_word_t cfg_wdata
);

  uers_pkg::cfg_t         cfg;
  uers_pkg::out_payload_t result;
  uers_pkg::out_payload_t out_data_r;
  uers_pkg::in_payload_t  in_data;

  logic s1_valid_r;
  logic echo_r;
  logic out_valid_r;
  logic s1_go;
  logic in_take;

  assign in_data = in_word.data;
  assign s1_go   = s1_valid_r && (!out_valid_r || out_word.ready);
  assign in_word.ready = !s1_valid_r || s1_go;
  assign in_take = in_word.valid && in_word.ready;

  uers_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uers_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step_en    (s1_go),
    .echo_level (echo_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      echo_r <= in_data.echo_level;
    end
    if (s1_go) begin
      out_data_r <= result;
    end
  end

  assign out_word.valid = out_valid_r;
  assign out_word.data  = out_data_r;

endmodule

// ----- design/uers_checker.sv -----
// ----------------------------------------------------------------------------
// uers_checker
// port-level checks of the echo ranging sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uers_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input uers_pkg::out_payload_t out_data
);

  `UERS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")
  `UERS_ASSERT(a_width_zero, clk, rst_n, out_valid && !out_data.width_valid |-> out_data.echo_width == '0, "width nonzero before capture")
  `UERS_ASSERT(a_ind_needs_width, clk, rst_n, out_valid && !out_data.indicator_on |-> out_data.width_valid, "indicator off without captured width")
  `UERS_ASSERT(a_accept_result, clk, rst_n, in_valid && in_ready |-> ##2 out_valid, "accepted word produced no result")

endmodule

bind ultrasonic_echo_ranging_sequencer uers_checker u_uers_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .out_data  (out_word.data)
);
